// ----- sv/nlp_pkg.sv -----
`timescale 1ns / 1ps

package nlp_pkg;

  localparam int unsigned SeqW  = 16;
  localparam int unsigned MaskW = 16;

  typedef struct packed {
    logic [SeqW-1:0]  base;
    logic [MaskW-1:0] mask;
  } nlp_entry_t;

  // What one transaction leaves for the output side: an entry closed by a far
  // number and/or the entry emitted at the end of the list.
  typedef struct packed {
    logic       close_v;
    nlp_entry_t close_entry;
    logic       fin_v;
    nlp_entry_t fin_entry;
  } nlp_rec_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } nlp_qstat_t;

endpackage

// ----- sv/nack_list_packer_top.sv -----
`timescale 1ns / 1ps
// A closed entry is written to a queue slot, then the record register, then the output.
// Throughput: one sequence number per cycle in when not stalled, one entry per cycle out
//   when not stalled; a number that closes an entry and ends the list yields two entries.
// The queue between packing and output holds Depth records; input stalls when it is full.
// Reset: asynchronous, active low; clears the open entry, the queue and the output valid.
module nack_list_packer_top #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] seq_number_i,
  input  logic        list_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] base_seq_o,
  output logic [15:0] follow_mask_o,
  output logic        final_entry_o
);
  import nlp_pkg::*;

  nlp_qstat_t qstat;
  nlp_rec_t   push_rec;
  nlp_rec_t   head;
  logic       push;
  logic       pop;

  nlp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .seq_number_i (seq_number_i),
    .list_end_i   (list_end_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .push_rec_o   (push_rec)
  );

  nlp_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .qstat_o    (qstat)
  );

  nlp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .base_seq_o    (base_seq_o),
    .follow_mask_o (follow_mask_o),
    .final_entry_o (final_entry_o)
  );

endmodule

// ----- sv/nlp_front.sv -----
`timescale 1ns / 1ps

module nlp_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [15:0]             seq_number_i,
  input  logic                    list_end_i,
  input  nlp_pkg::nlp_qstat_t     qstat_i,
  output logic                    push_o,
  output nlp_pkg::nlp_rec_t       push_rec_o
);
  import nlp_pkg::*;

  logic             open_q, open_d;
  logic [SeqW-1:0]  base_q, base_d;
  logic [MaskW-1:0] mask_q, mask_d;

  logic             accept;
  logic [SeqW-1:0]  gap;
  logic [SeqW-1:0]  gap_m1;
  logic             near;
  logic [SeqW-1:0]  new_base;
  logic [MaskW-1:0] new_mask;
  nlp_rec_t         rec;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign gap    = seq_number_i - base_q;
  assign gap_m1 = gap - SeqW'(1);
  // distance 1..16 lands in the mask
  assign near   = (gap != '0) && (gap_m1 < SeqW'(MaskW));

  always_comb begin
    new_base          = base_q;
    new_mask          = mask_q;
    rec               = '0;
    if (!open_q) begin
      new_base = seq_number_i;
      new_mask = '0;
    end else if (near) begin
      new_mask = mask_q | (MaskW'(1) << gap_m1[3:0]);
    end else if (gap != '0) begin
      rec.close_v          = 1'b1;
      rec.close_entry.base = base_q;
      rec.close_entry.mask = mask_q;
      new_base             = seq_number_i;
      new_mask             = '0;
    end
    if (list_end_i) begin
      rec.fin_v          = 1'b1;
      rec.fin_entry.base = new_base;
      rec.fin_entry.mask = new_mask;
    end
  end

  always_comb begin
    open_d = open_q;
    base_d = base_q;
    mask_d = mask_q;
    if (accept) begin
      if (list_end_i) begin
        open_d = 1'b0;
        base_d = '0;
        mask_d = '0;
      end else begin
        open_d = 1'b1;
        base_d = new_base;
        mask_d = new_mask;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      base_q <= '0;
      mask_q <= '0;
    end else begin
      open_q <= open_d;
      base_q <= base_d;
      mask_q <= mask_d;
    end
  end

  assign push_o     = accept && (rec.close_v || rec.fin_v);
  assign push_rec_o = rec;

endmodule

// ----- sv/nlp_queue.sv -----
`timescale 1ns / 1ps

module nlp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  nlp_pkg::nlp_rec_t   push_rec_i,
  input  logic                pop_i,
  output nlp_pkg::nlp_rec_t   head_o,
  output nlp_pkg::nlp_qstat_t qstat_o
);
  import nlp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nlp_rec_t        slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign qstat_o.full      = (count_q == CntW'(Depth));
  assign qstat_o.not_empty = (count_q != '0);
  assign head_o            = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_rec_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CntW'(Depth)))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not advance on push");

endmodule

// ----- sv/nlp_back.sv -----
`timescale 1ns / 1ps

module nlp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nlp_pkg::nlp_rec_t   head_i,
  input  nlp_pkg::nlp_qstat_t qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         base_seq_o,
  output logic [15:0]         follow_mask_o,
  output logic                final_entry_o
);
  import nlp_pkg::*;

  nlp_rec_t   rec_q, rec_d;
  logic       out_valid_q, out_valid_d;
  nlp_entry_t out_entry_q, out_entry_d;
  logic       out_final_q, out_final_d;

  logic load;
  logic has;
  logic frees;

  assign load  = !out_valid_q || !out_stall_i;
  assign has   = rec_q.close_v || rec_q.fin_v;
  // slot empties if it holds nothing, or a single entry that goes out now
  assign frees = !has || (load && !(rec_q.close_v && rec_q.fin_v));
  assign pop_o = qstat_i.not_empty && frees;

  always_comb begin
    rec_d       = rec_q;
    out_valid_d = out_valid_q;
    out_entry_d = out_entry_q;
    out_final_d = out_final_q;
    if (load) begin
      out_valid_d = has;
      if (rec_q.close_v) begin
        out_entry_d   = rec_q.close_entry;
        out_final_d   = 1'b0;
        rec_d.close_v = 1'b0;
      end else if (rec_q.fin_v) begin
        out_entry_d = rec_q.fin_entry;
        out_final_d = 1'b1;
        rec_d.fin_v = 1'b0;
      end
    end
    if (pop_o) begin
      rec_d = head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q       <= '0;
      out_valid_q <= 1'b0;
      out_entry_q <= '0;
      out_final_q <= 1'b0;
    end else begin
      rec_q       <= rec_d;
      out_valid_q <= out_valid_d;
      out_entry_q <= out_entry_d;
      out_final_q <= out_final_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign base_seq_o    = out_entry_q.base;
  assign follow_mask_o = out_entry_q.mask;
  assign final_entry_o = out_final_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import nlp_pkg::*;

  typedef struct {
    logic [15:0] seq;
    logic        ends;
    bit          wait_drain;
    int unsigned pace;
  } seq_item_t;

  typedef struct {
    nlp_entry_t entry;
    logic       fin;
  } nack_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] seq_number_i = '0;
  logic        list_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] base_seq_o;
  logic [15:0] follow_mask_o;
  logic        final_entry_o;

  seq_item_t   seq_feed[$];
  nack_entry_t nack_entries_due[$];

  logic        run_open = 1'b0;
  logic [15:0] run_base = '0;
  logic [15:0] run_mask = '0;

  int unsigned mismatch_count = 0;
  int unsigned items_taken = 0;
  int unsigned feed_pace = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  nack_list_packer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .seq_number_i  (seq_number_i),
    .list_end_i    (list_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .base_seq_o    (base_seq_o),
    .follow_mask_o (follow_mask_o),
    .final_entry_o (final_entry_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #400000;
    $display("nack_list_packer_top test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    end
  endtask

  task automatic push_entry(input logic fin);
    nack_entry_t e;
    e.entry.base = run_base;
    e.entry.mask = run_mask;
    e.fin        = fin;
    nack_entries_due.push_back(e);
  endtask

  // Fold one sequence number into the open NACK entry; queue the entries it closes or ends.
  task automatic pack_seq_number(input logic [15:0] seq, input logic ends);
    logic [15:0] gap;
    logic [3:0]  bit_idx;
    gap     = seq - run_base;
    bit_idx = 4'(gap - 16'd1);
    if (!run_open) begin
      run_base = seq;
      run_mask = '0;
      run_open = 1'b1;
    end else if (gap >= 16'd1 && gap <= 16'(MaskW)) begin
      run_mask[bit_idx] = 1'b1;
    end else if (gap != 16'd0) begin
      push_entry(1'b0);
      run_base = seq;
      run_mask = '0;
    end
    if (ends) begin
      push_entry(1'b1);
      run_open = 1'b0;
      run_base = '0;
      run_mask = '0;
    end
  endtask

  task automatic add_item(input logic [15:0] seq, input logic ends, input bit drain);
    seq_item_t it;
    it.seq        = seq;
    it.ends       = ends;
    it.wait_drain = drain;
    it.pace       = (seq_feed.size() < 190) ? 0 : ((seq_feed.size() < 380) ? 1 : 2);
    seq_feed.push_back(it);
  endtask

  // Driver: hold the payload while stalled, otherwise advance or idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_seq
    int unsigned gap_pct;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      seq_number_i <= '0;
      list_end_i   <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        pack_seq_number(seq_number_i, list_end_i);
        items_taken <= items_taken + 1;
      end
      if (seq_feed.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        gap_pct = (seq_feed[0].pace == 0) ? 28 : ((seq_feed[0].pace == 1) ? 54 : 0);
        if ((seq_feed[0].wait_drain && nack_entries_due.size() != 0) ||
            $urandom_range(99) < gap_pct) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i   <= 1'b1;
          seq_number_i <= seq_feed[0].seq;
          list_end_i   <= seq_feed[0].ends;
          feed_pace    <= seq_feed[0].pace;
          void'(seq_feed.pop_front());
        end
      end
    end
  end

  // Receiver stall, with one long hold-off so the internal queue backs up.
  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    int unsigned stall_pct;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && items_taken >= 420) begin
      out_stall_i <= 1'b1;
      hold_left   <= 80;
      hold_done   <= 1'b1;
    end else begin
      stall_pct   = (feed_pace == 0) ? 54 : ((feed_pace == 1) ? 28 : 0);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_entry
    nack_entry_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (nack_entries_due.size() == 0) begin
        report_mismatch("unexpected entry, base_seq", base_seq_o, 16'h0);
      end else begin
        want = nack_entries_due.pop_front();
        if (base_seq_o !== want.entry.base) begin
          report_mismatch("base_seq", base_seq_o, want.entry.base);
        end
        if (follow_mask_o !== want.entry.mask) begin
          report_mismatch("follow_mask", follow_mask_o, want.entry.mask);
        end
        if (final_entry_o !== want.fin) begin
          report_mismatch("final_entry", 16'(final_entry_o), 16'(want.fin));
        end
      end
    end
  end

  initial begin : fill_feed
    logic [15:0] cur;
    logic [15:0] list_base;
    int unsigned len;
    int unsigned r;
    bit          dense;
    bit          drain;

    // Single-number list, ended at once.
    add_item(16'h0000, 1'b1, 1'b0);
    // Adjacent, span edge, just past span, repeated base, duplicate bit,
    // then a far number that closes and ends together.
    add_item(16'd100, 1'b0, 1'b0);
    add_item(16'd101, 1'b0, 1'b0);
    add_item(16'd116, 1'b0, 1'b0);
    add_item(16'd117, 1'b0, 1'b0);
    add_item(16'd117, 1'b0, 1'b0);
    add_item(16'd118, 1'b0, 1'b0);
    add_item(16'd118, 1'b0, 1'b0);
    add_item(16'hFFFF, 1'b1, 1'b0);
    // Mask reaching across the 16-bit wrap.
    add_item(16'hFFF8, 1'b0, 1'b1);
    add_item(16'hFFFF, 1'b0, 1'b0);
    add_item(16'h0000, 1'b0, 1'b0);
    add_item(16'h0007, 1'b0, 1'b0);
    add_item(16'h0008, 1'b1, 1'b0);
    // Number just below the base closes the entry.
    add_item(16'd200, 1'b0, 1'b0);
    add_item(16'd199, 1'b1, 1'b0);
    // Repeated base that also ends the list.
    add_item(16'h1234, 1'b0, 1'b0);
    add_item(16'h1234, 1'b1, 1'b0);
    add_item(16'h8000, 1'b0, 1'b0);
    add_item(16'h8010, 1'b1, 1'b0);

    while (seq_feed.size() < 570) begin
      if ($urandom_range(9) == 0) begin
        add_item(16'($urandom), ($urandom_range(7) == 0), 1'b0);
      end else begin
        dense     = ($urandom_range(5) == 0);
        drain     = ($urandom_range(15) == 0);
        len       = dense ? 17 : $urandom_range(1, 20);
        list_base = 16'($urandom);
        cur       = list_base;
        for (int k = 0; k < len; k++) begin
          if (k != 0) begin
            r = dense ? 0 : $urandom_range(19);
            if (r < 13) cur = cur + 16'($urandom_range(dense ? 1 : 4, 1));
            else if (r < 15) cur = cur;
            else if (r < 17) cur = cur - 16'($urandom_range(3, 1));
            else if (r < 19) cur = list_base + 16'($urandom_range(17, 15));
            else cur = 16'($urandom);
          end
          add_item(cur, (k == len - 1), drain && k == 0);
        end
      end
    end

    do @(negedge clk_i);
    while (seq_feed.size() != 0 || in_valid_i || nack_entries_due.size() != 0);
    repeat (8) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("nack_list_packer_top test passed");
    end else begin
      $display("nack_list_packer_top test failed");
    end
    $finish;
  end

endmodule
